>>> hdl/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

   // Request kinds; codes above KIND_QUERY act as a query
   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [2:0] KIND_POP_BACK   = 3'd3;
   localparam logic [2:0] KIND_QUERY      = 3'd4;

   // Result status codes
   localparam logic [1:0] STATUS_DONE       = 2'd0;
   localparam logic [1:0] STATUS_FULL_REJ   = 2'd1;
   localparam logic [1:0] STATUS_EMPTY_REJ  = 2'd2;

   // Word reported for "nothing there"
   localparam logic signed [31:0] WORD_NONE = -32'sd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_FETCH,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage

`default_nettype wire

>>> hdl/cdq_if.sv
`default_nettype none

interface cdq_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic signed [31:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface cdq_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] popped_value;
   logic signed [31:0] front_value;
   logic signed [31:0] rear_value;
   logic               is_empty;
   logic               is_full;
   logic [4:0]         occupancy;

   modport source (output valid, output status, output popped_value, output front_value,
                   output rear_value, output is_empty, output is_full, output occupancy,
                   input ready);
   modport sink   (input valid, input status, input popped_value, input front_value,
                   input rear_value, input is_empty, input is_full, input occupancy,
                   output ready);
endinterface

`default_nettype wire

>>> hdl/cdq_ctrl.sv
`default_nettype none

module cdq_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output cdq_pkg::cmd_type    cmd
);

   cdq_pkg::state_type state_ff;
   cdq_pkg::state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cdq_pkg::ST_IDLE: begin
            if (req_valid) state_in = cdq_pkg::ST_UPDATE;
         end
         cdq_pkg::ST_UPDATE: state_in = cdq_pkg::ST_FETCH;
         cdq_pkg::ST_FETCH:  state_in = cdq_pkg::ST_RESP;
         cdq_pkg::ST_RESP: begin
            if (rsp_ready) state_in = cdq_pkg::ST_IDLE;
         end
         default: state_in = cdq_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         cdq_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         cdq_pkg::ST_UPDATE: cmd.execute = 1'b1;
         cdq_pkg::ST_FETCH:  ;
         cdq_pkg::ST_RESP:   rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/cdq_datapath.sv
`default_nettype none

module cdq_datapath #(
   parameter int DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cdq_pkg::cmd_type   cmd,
   input  wire logic [2:0]         req_kind,
   input  wire logic signed [31:0] req_value,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_popped_value,
   output logic signed [31:0]      rsp_front_value,
   output logic signed [31:0]      rsp_rear_value,
   output logic                    rsp_is_empty,
   output logic                    rsp_is_full,
   output logic [4:0]              rsp_occupancy
);

   localparam int IdxW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   logic [2:0]         kind_ff;
   logic signed [31:0] value_ff;
   logic [IdxW-1:0]    head_ff, head_in;
   logic [IdxW-1:0]    tail_ff, tail_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [1:0]         status_ff, status_in;
   logic signed [31:0] popped_ff, popped_in;
   logic signed [31:0] rd_head_ff;
   logic signed [31:0] rd_tail_ff;
   logic signed [31:0] store_ff [DEPTH];

   logic               wr_en;
   logic [IdxW-1:0]    wr_addr;
   logic               is_push, is_pop, empty, full;
   logic [IdxW-1:0]    head_down, tail_up;
   logic [CntW+4:0]    occ_ext;

   assign is_push   = (kind_ff == cdq_pkg::KIND_PUSH_FRONT) ||
                      (kind_ff == cdq_pkg::KIND_PUSH_BACK);
   assign is_pop    = (kind_ff == cdq_pkg::KIND_POP_FRONT) ||
                      (kind_ff == cdq_pkg::KIND_POP_BACK);
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CntW'(DEPTH));
   assign head_down = (head_ff == '0) ? IdxW'(DEPTH - 1) : head_ff - IdxW'(1);
   assign tail_up   = (tail_ff >= IdxW'(DEPTH - 1)) ? '0 : tail_ff + IdxW'(1);

   // Apply one request to indices and count; pick the store write
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = status_ff;
      popped_in = popped_ff;
      wr_en     = 1'b0;
      wr_addr   = head_ff;
      if (cmd.execute) begin
         status_in = cdq_pkg::STATUS_DONE;
         popped_in = cdq_pkg::WORD_NONE;
         if (is_push) begin
            if (full) begin
               status_in = cdq_pkg::STATUS_FULL_REJ;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CntW'(1);
               if (empty) begin
                  head_in = '0;
                  tail_in = '0;
                  wr_addr = '0;
               end else if (kind_ff == cdq_pkg::KIND_PUSH_FRONT) begin
                  head_in = head_down;
                  wr_addr = head_down;
               end else begin
                  tail_in = tail_up;
                  wr_addr = tail_up;
               end
            end
         end else if (is_pop) begin
            if (empty) begin
               status_in = cdq_pkg::STATUS_EMPTY_REJ;
            end else begin
               popped_in = (kind_ff == cdq_pkg::KIND_POP_FRONT) ? rd_head_ff : rd_tail_ff;
               count_in  = count_ff - CntW'(1);
               if (count_ff == CntW'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end else if (kind_ff == cdq_pkg::KIND_POP_FRONT) begin
                  head_in = (head_ff >= IdxW'(DEPTH - 1)) ? '0 : head_ff + IdxW'(1);
               end else begin
                  tail_in = (tail_ff == '0) ? IdxW'(DEPTH - 1) : tail_ff - IdxW'(1);
               end
            end
         end
      end
   end

   // Hold the request while it is worked on
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         value_ff <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   // Word store: one write port, registered reads at the two ends
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= value_ff;
      end
      rd_head_ff <= store_ff[head_ff];
      rd_tail_ff <= store_ff[tail_ff];
   end

   assign occ_ext          = {5'b0, count_ff};
   assign rsp_status       = status_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_front_value  = empty ? cdq_pkg::WORD_NONE : rd_head_ff;
   assign rsp_rear_value   = empty ? cdq_pkg::WORD_NONE : rd_tail_ff;
   assign rsp_is_empty     = empty;
   assign rsp_is_full      = full;
   assign rsp_occupancy    = occ_ext[4:0];

endmodule

`default_nettype wire

>>> hdl/circular_deque_core.sv
// A result is valid in ST_RESP, after the ST_UPDATE and ST_FETCH states (update, end read).
// Items are taken one at a time; the registered read of the word store
//   is taken twice per item, once for the popped word and once for the new ends.
// A stalled result holds the block; the next item is taken after the result is taken.
// Reset (synchronous, active high) empties the queue and clears the indices;
//   the word store is not cleared and needs no clearing pass.
`default_nettype none

module circular_deque_core #(
   parameter int DEPTH = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   cdq_req_if.sink    req_port,
   cdq_rsp_if.source  rsp_port
);

   cdq_pkg::cmd_type cmd;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .cmd       (cmd)
   );

   cdq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_kind         (req_port.kind),
      .req_value        (req_port.value),
      .rsp_status       (rsp_port.status),
      .rsp_popped_value (rsp_port.popped_value),
      .rsp_front_value  (rsp_port.front_value),
      .rsp_rear_value   (rsp_port.rear_value),
      .rsp_is_empty     (rsp_port.is_empty),
      .rsp_is_full      (rsp_port.is_full),
      .rsp_occupancy    (rsp_port.occupancy)
   );

endmodule

`default_nettype wire

>>> hdl/cdq_checker.sv
`default_nettype none

module cdq_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [1:0]         rsp_status,
   input wire logic signed [31:0] rsp_popped_value,
   input wire logic signed [31:0] rsp_front_value,
   input wire logic signed [31:0] rsp_rear_value,
   input wire logic               rsp_is_empty,
   input wire logic               rsp_is_full
);

   // A waiting result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // One item in flight: no new item right after one is taken
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("item taken while another is in flight");

   // An empty queue reports no end words and is not full
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |->
         rsp_front_value == cdq_pkg::WORD_NONE && rsp_rear_value == cdq_pkg::WORD_NONE &&
         !rsp_is_full)
      else $error("empty queue reports end words");

   // A rejected request pops nothing
   a_reject_no_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != cdq_pkg::STATUS_DONE |->
         rsp_popped_value == cdq_pkg::WORD_NONE)
      else $error("rejected request returned a word");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_port.valid),
   .req_ready        (req_port.ready),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_status       (rsp_port.status),
   .rsp_popped_value (rsp_port.popped_value),
   .rsp_front_value  (rsp_port.front_value),
   .rsp_rear_value   (rsp_port.rear_value),
   .rsp_is_empty     (rsp_port.is_empty),
   .rsp_is_full      (rsp_port.is_full)
);

`default_nettype wire

>>> bench/circular_deque_core_tb.sv
`timescale 1ns / 1ps

module circular_deque_core_tb;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int NOTE_LIMIT  = 10;

   // Spare request codes; the block treats them as a query
   localparam logic [2:0] KIND_SPARE_5 = 3'd5;
   localparam logic [2:0] KIND_SPARE_6 = 3'd6;
   localparam logic [2:0] KIND_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] popped;
      logic signed [31:0] front_word;
      logic signed [31:0] rear_word;
      logic               empty_flag;
      logic               full_flag;
      logic [4:0]         occupancy;
   } deque_result_type;

   logic clock;
   logic reset;

   cdq_req_if req_bus ();
   cdq_rsp_if rsp_bus ();

   circular_deque_core #(.DEPTH(DEPTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // Shadow copy of the deque
   logic signed [31:0] shadow_words [0:DEPTH-1];
   int                 front_idx;
   int                 rear_idx;
   int                 word_count;

   deque_result_type pending_results [$];

   int mismatch_count;
   int cycle_count;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_left;

   // 2 ns clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Advance the shadow deque by one request and return the result it gives
   function automatic deque_result_type predict_deque(logic [2:0] kind,
                                                      logic signed [31:0] value);
      deque_result_type res;
      int               at;
      res.status = cdq_pkg::STATUS_DONE;
      res.popped = cdq_pkg::WORD_NONE;
      if (kind == cdq_pkg::KIND_PUSH_FRONT || kind == cdq_pkg::KIND_PUSH_BACK) begin
         if (word_count >= DEPTH) begin
            res.status = cdq_pkg::STATUS_FULL_REJ;
         end else begin
            if (word_count == 0) begin
               front_idx       = 0;
               rear_idx        = 0;
               shadow_words[0] = value;
            end else if (kind == cdq_pkg::KIND_PUSH_FRONT) begin
               front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
               shadow_words[front_idx] = value;
            end else begin
               rear_idx = (rear_idx >= DEPTH - 1) ? 0 : rear_idx + 1;
               shadow_words[rear_idx] = value;
            end
            word_count++;
         end
      end else if (kind == cdq_pkg::KIND_POP_FRONT || kind == cdq_pkg::KIND_POP_BACK) begin
         if (word_count == 0) begin
            res.status = cdq_pkg::STATUS_EMPTY_REJ;
         end else begin
            at = (kind == cdq_pkg::KIND_POP_FRONT) ? front_idx : rear_idx;
            res.popped       = shadow_words[at];
            shadow_words[at] = cdq_pkg::WORD_NONE;
            word_count--;
            if (word_count == 0) begin
               front_idx = 0;
               rear_idx  = 0;
            end else if (kind == cdq_pkg::KIND_POP_FRONT) begin
               front_idx = (front_idx >= DEPTH - 1) ? 0 : front_idx + 1;
            end else begin
               rear_idx = (rear_idx == 0) ? DEPTH - 1 : rear_idx - 1;
            end
         end
      end
      res.front_word = (word_count == 0) ? cdq_pkg::WORD_NONE : shadow_words[front_idx];
      res.rear_word  = (word_count == 0) ? cdq_pkg::WORD_NONE : shadow_words[rear_idx];
      res.empty_flag = (word_count == 0);
      res.full_flag  = (word_count >= DEPTH);
      res.occupancy  = word_count[4:0];
      return res;
   endfunction

   // Drive ready: hold off while a long stall is pending, else stall at random
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check each accepted result against the oldest prediction
   always @(posedge clock) begin
      deque_result_type seen;
      deque_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen.status     = rsp_bus.status;
         seen.popped     = rsp_bus.popped_value;
         seen.front_word = rsp_bus.front_value;
         seen.rear_word  = rsp_bus.rear_value;
         seen.empty_flag = rsp_bus.is_empty;
         seen.full_flag  = rsp_bus.is_full;
         seen.occupancy  = rsp_bus.occupancy;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= NOTE_LIMIT)
               $display("unexpected result at cycle %0d: st=%0d pop=%0d occ=%0d",
                        cycle_count, seen.status, seen.popped, seen.occupancy);
         end else begin
            want = pending_results[0];
            pending_results.delete(0);
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= NOTE_LIMIT) begin
                  $display("mismatch at cycle %0d", cycle_count);
                  $display("  expected st=%0d pop=%0d front=%0d rear=%0d e=%0b f=%0b occ=%0d",
                           want.status, want.popped, want.front_word, want.rear_word,
                           want.empty_flag, want.full_flag, want.occupancy);
                  $display("  actual   st=%0d pop=%0d front=%0d rear=%0d e=%0b f=%0b occ=%0d",
                           seen.status, seen.popped, seen.front_word, seen.rear_word,
                           seen.empty_flag, seen.full_flag, seen.occupancy);
               end
            end
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("circular_deque_core_tb: done, errors");
         $finish;
      end
   end

   // Offer one item, idling first at random, and predict it once it is taken
   task automatic send_item(input logic [2:0] kind, input logic signed [31:0] value);
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.value <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_results.insert(pending_results.size(), predict_deque(kind, value));
   endtask

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return cdq_pkg::WORD_NONE;
         3: return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   // Empty-queue rejects, spare codes, extreme words, last-word pops
   task automatic test_directed_cases();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_item(cdq_pkg::KIND_POP_FRONT, $urandom);
      send_item(cdq_pkg::KIND_POP_BACK, $urandom);
      send_item(cdq_pkg::KIND_QUERY, $urandom);
      send_item(KIND_SPARE_5, $urandom);
      send_item(KIND_SPARE_6, $urandom);
      send_item(KIND_SPARE_7, $urandom);
      send_item(cdq_pkg::KIND_PUSH_FRONT, 32'sh7FFF_FFFF);
      send_item(cdq_pkg::KIND_PUSH_BACK, 32'sh8000_0000);
      send_item(cdq_pkg::KIND_PUSH_FRONT, cdq_pkg::WORD_NONE);
      send_item(cdq_pkg::KIND_PUSH_BACK, 32'sd0);
      send_item(cdq_pkg::KIND_QUERY, 32'sh5555_AAAA);
      send_item(cdq_pkg::KIND_POP_BACK, $urandom);
      send_item(cdq_pkg::KIND_POP_FRONT, $urandom);
      send_item(cdq_pkg::KIND_POP_BACK, $urandom);
      send_item(cdq_pkg::KIND_POP_FRONT, $urandom);
      send_item(cdq_pkg::KIND_PUSH_BACK, 32'sh1234_5678);
      send_item(cdq_pkg::KIND_POP_FRONT, $urandom);
      send_item(KIND_SPARE_7, 32'shAAAA_5555);
   endtask

   // Alternate fill and drain runs so the deque wraps, fills and empties
   task automatic test_random_traffic(input int count, input int snd_pct, input int rcv_pct);
      bit         filling;
      int         roll;
      logic [2:0] kind;
      filling       = 1'b1;
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      repeat (count) begin
         if (filling && word_count == DEPTH && $urandom_range(2) == 0)
            filling = 1'b0;
         else if (!filling && word_count == 0 && $urandom_range(2) == 0)
            filling = 1'b1;
         else if ($urandom_range(99) < 3)
            filling = !filling;
         roll = $urandom_range(99);
         if (roll < 6)
            kind = 3'($urandom_range(cdq_pkg::KIND_QUERY, KIND_SPARE_7));
         else if (roll < 10)
            kind = 3'($urandom_range(7));
         else if (($urandom_range(99) < 80) == filling)
            kind = $urandom_range(1) ? cdq_pkg::KIND_PUSH_BACK : cdq_pkg::KIND_PUSH_FRONT;
         else
            kind = $urandom_range(1) ? cdq_pkg::KIND_POP_BACK : cdq_pkg::KIND_POP_FRONT;
         send_item(kind, pick_word());
      end
   endtask

   // Stall the result side for a long stretch while items keep coming
   task automatic test_result_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left     = 80;
      repeat (24)
         send_item($urandom_range(1) ? cdq_pkg::KIND_PUSH_BACK : cdq_pkg::KIND_POP_FRONT,
                   pick_word());
   endtask

   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.kind   = cdq_pkg::KIND_QUERY;
      req_bus.value  = 32'sd0;
      rsp_bus.ready  = 1'b0;
      mismatch_count = 0;
      cycle_count    = 0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      hold_left      = 0;
      front_idx      = 0;
      rear_idx       = 0;
      word_count     = 0;
      for (int i = 0; i < DEPTH; i++)
         shadow_words[i] = 32'sd0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_traffic(140, 36, 82);
      test_random_traffic(140, 82, 36);
      test_result_backpressure();
      test_random_traffic(140, 0, 0);

      // Drop valid and let the last results drain
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0)
         $display("circular_deque_core_tb: done, clean");
      else
         $display("circular_deque_core_tb: done, errors");
      $finish;
   end

endmodule

>>> filelist.f
hdl/cdq_pkg.sv
hdl/cdq_if.sv
hdl/cdq_ctrl.sv
hdl/cdq_datapath.sv
hdl/circular_deque_core.sv
hdl/cdq_checker.sv
bench/circular_deque_core_tb.sv
